// ===== hdl/smi_pkg.sv =====
package smi_pkg;

  localparam logic [31:0] INSN_MASK  = 32'h9FF8_0400;
  localparam logic [31:0] INSN_MATCH = 32'h0F00_0400;
  localparam logic [3:0]  CMODE_FP   = 4'hF;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 200;

  typedef enum logic [1:0] {
    ST_EXECUTED  = 2'd0,
    ST_UNDEFINED = 2'd1,
    ST_UNHANDLED = 2'd2
  } smi_status_e;

  typedef struct packed {
    logic        matched;
    logic        reserved;
    logic        op;
    logic [3:0]  cmode;
    logic [4:0]  rd;
    logic [63:0] pat;
  } smi_dec_t;

  typedef struct packed {
    logic [63:0] next_pc;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  dest_register;
    smi_status_e status;
  } smi_result_t;

endpackage

// ===== hdl/smi_decode.sv =====
module smi_decode (
  input  logic [31:0]       insn_i,
  input  logic              full_width_i,
  output smi_pkg::smi_dec_t dec_o
);

  logic [7:0]  imm8;
  logic        a_bit;
  logic        b_bit;
  logic [5:0]  low6;
  logic        op;
  logic        o2;
  logic [3:0]  cmode;
  logic [63:0] pat;
  logic        reserved;
  logic [63:0] byte_mask;

  assign imm8  = {insn_i[18:16], insn_i[9:5]};
  assign a_bit = imm8[7];
  assign b_bit = imm8[6];
  assign low6  = imm8[5:0];
  assign op    = insn_i[29];
  assign o2    = insn_i[11];
  assign cmode = insn_i[15:12];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_mask[i*8 +: 8] = {8{imm8[i]}};
    end
  end

  always_comb begin
    pat      = '0;
    reserved = 1'b0;
    if (o2) begin
      reserved = op || (cmode != smi_pkg::CMODE_FP);
      pat      = {4{a_bit, ~b_bit, {2{b_bit}}, low6, 6'b0}};
    end else begin
      unique case (cmode[3:1])
        3'd0: pat = {2{24'b0, imm8}};
        3'd1: pat = {2{16'b0, imm8, 8'b0}};
        3'd2: pat = {2{8'b0, imm8, 16'b0}};
        3'd3: pat = {2{imm8, 24'b0}};
        3'd4: pat = {4{8'b0, imm8}};
        3'd5: pat = {4{imm8, 8'b0}};
        3'd6: begin
          if (cmode[0]) pat = {2{8'b0, imm8, 16'hFFFF}};
          else          pat = {2{16'b0, imm8, 8'hFF}};
        end
        3'd7: begin
          priority if (!cmode[0] && !op) begin
            pat = {8{imm8}};
          end else if (!cmode[0]) begin
            pat = byte_mask;
          end else if (!op) begin
            pat = {2{a_bit, ~b_bit, {5{b_bit}}, low6, 19'b0}};
          end else begin
            reserved = !full_width_i;
            pat      = {a_bit, ~b_bit, {8{b_bit}}, low6, 48'b0};
          end
        end
        default: pat = '0;
      endcase
    end
  end

  assign dec_o.matched  = (insn_i & smi_pkg::INSN_MASK) == smi_pkg::INSN_MATCH;
  assign dec_o.reserved = reserved;
  assign dec_o.op       = op;
  assign dec_o.cmode    = cmode;
  assign dec_o.rd       = insn_i[4:0];
  assign dec_o.pat      = pat;

endmodule

// ===== hdl/smi_vrf.sv =====
module smi_vrf #(
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [127:0]             rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [127:0]             wdata_i
);

  logic [127:0]     mem [Depth];
  logic [127:0]     rdata_q;
  logic [Depth-1:0] valid_q;
  logic [Depth-1:0] valid_d;

  always_comb begin
    valid_d = valid_q;
    if (we_i) valid_d[waddr_i] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) begin
      priority if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else if (valid_q[raddr_i]) begin
        rdata_q <= mem[raddr_i];
      end else begin
        rdata_q <= '0;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/simd_modified_immediate_exec_unit.sv =====
// channel   direction  tdata fields (lsb first)                          tuser  tlast
// s_axis    in         instruction[31:0] full_width[32] current_pc[96:33] -      -
// m_axis    out        status[1:0] dest_register[6:2] result_low[70:7]    -      -
//                      result_high[134:71] next_pc[198:135]
//
// One instruction per cycle unless the result stalls: the register file is read as the beat is accepted,
// then one pass of decode, expand and read-modify-write, then the result register.
// The vector register file write lands as the instruction leaves the input
// register; a beat accepted in that cycle takes the written value by bypass.
// Reset clears every vector register to zero at once (per-entry valid bits).
// A stalled result holds the input register; s_axis_tready drops only then.
module simd_modified_immediate_exec_unit #(
  parameter int unsigned VECTOR_REGISTERS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [smi_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // instruction, full_width, current_pc
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [smi_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // status, dest_register, result_low,
                                                           // result_high, next_pc
);

  localparam int unsigned IdxW = $clog2(VECTOR_REGISTERS);

  logic               s1_valid_q;
  logic               s1_valid_d;
  logic [31:0]        s1_insn_q;
  logic               s1_full_q;
  logic [63:0]        s1_pc_q;
  logic               out_valid_q;
  logic               out_valid_d;
  smi_pkg::smi_result_t out_q;
  smi_pkg::smi_result_t res;
  smi_pkg::smi_dec_t  dec;
  logic               s1_adv;
  logic               in_fire;
  logic               executed;
  logic [127:0]       rdata;
  logic [63:0]        lo;
  logic [63:0]        hi;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : ((out_valid_q && m_axis_tready) ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_insn_q <= s_axis_tdata[31:0];
      s1_full_q <= s_axis_tdata[32];
      s1_pc_q   <= s_axis_tdata[96:33];
    end
    if (s1_adv) out_q <= res;
  end

  smi_decode u_decode (
    .insn_i       (s1_insn_q),
    .full_width_i (s1_full_q),
    .dec_o        (dec)
  );

  assign executed = dec.matched && !dec.reserved;

  smi_vrf #(
    .Depth (VECTOR_REGISTERS)
  ) u_vrf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (in_fire),
    .raddr_i (s_axis_tdata[IdxW-1:0]),
    .rdata_o (rdata),
    .we_i    (s1_adv && executed),
    .waddr_i (dec.rd[IdxW-1:0]),
    .wdata_i ({hi, lo})
  );

  always_comb begin
    lo = rdata[63:0];
    hi = rdata[127:64];
    priority if (dec.cmode[0] && (dec.cmode[3:2] != 2'b11)) begin
      if (dec.op) begin
        lo = lo & ~dec.pat;
        hi = hi & ~dec.pat;
      end else begin
        lo = lo | dec.pat;
        hi = hi | dec.pat;
      end
    end else if (dec.op && (dec.cmode[3:1] != 3'b111)) begin
      lo = ~dec.pat;
      hi = ~dec.pat;
    end else begin
      lo = dec.pat;
      hi = dec.pat;
    end
    if (!s1_full_q) hi = '0;
  end

  always_comb begin
    res.next_pc       = s1_pc_q;
    res.result_high   = '0;
    res.result_low    = '0;
    res.dest_register = '0;
    res.status        = smi_pkg::ST_UNHANDLED;
    if (dec.matched) begin
      if (dec.reserved) begin
        res.status = smi_pkg::ST_UNDEFINED;
      end else begin
        res.status        = smi_pkg::ST_EXECUTED;
        res.dest_register = dec.rd;
        res.result_low    = lo;
        res.result_high   = hi;
        res.next_pc       = s1_pc_q + 64'd4;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

`ifndef SYNTH
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != smi_pkg::ST_EXECUTED)) |->
      (out_q.result_low == '0 && out_q.result_high == '0 && out_q.dest_register == '0))
    else $error("non-executed result carries data");

  a_half_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && executed && !s1_full_q) |-> (hi == '0))
    else $error("64-bit form writes upper half");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !m_axis_tready) |=>
      (s1_valid_q && $stable(s1_insn_q) && $stable(s1_pc_q)))
    else $error("input register moved during stall");

  a_exec_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !executed) |=> (out_q.next_pc == $past(s1_pc_q)))
    else $error("pc advanced without execution");
`endif

endmodule
